// ===== hw/rtl/tbik_pkg.sv =====
// Package for the two-bone leg IK solver: pipeline stage record, stage numbering,
// fixed-point constants and the small arithmetic helpers shared by the stages.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tbik_pkg;

  localparam int CW = 32;  // coordinate width
  localparam int FB = 16;  // fraction bits
  localparam int ONE = 1 << FB;

  localparam int K_CENT     = ((1 << FB) + 50) / 100;
  localparam int K_MILLI    = ((1 << FB) + 500) / 1000;
  localparam int K_ANKLE    = ((8 << FB) + 50) / 100;
  localparam longint K_AXIS_MIN = ((64'sd1 <<< (2 * FB)) + 500) / 1000;

  // Square root and divider step counts.
  localparam int SQ1_STEPS = 31;
  localparam int SQ2_STEPS = FB + 1;
  localparam int DIV_STEPS = FB + 1;
  localparam int CDIV_STEPS = FB;

  // Stage numbering: pipe[k] is the register after stage k.
  localparam int ST_IN = 0;
  localparam int ST_A1 = ST_IN + 1;
  localparam int ST_A2 = ST_A1 + 1;
  localparam int ST_A3 = ST_A2 + 1;
  localparam int ST_Q1 = ST_A3 + 1;
  localparam int ST_B1 = ST_Q1 + SQ1_STEPS;
  localparam int ST_B2 = ST_B1 + 1;
  localparam int ST_B3 = ST_B2 + 1;
  localparam int ST_B4 = ST_B3 + 1;
  localparam int ST_D  = ST_B4 + 1;
  localparam int ST_E1 = ST_D + DIV_STEPS;
  localparam int ST_E2 = ST_E1 + 1;
  localparam int ST_E3 = ST_E2 + 1;
  localparam int ST_Q2 = ST_E3 + 1;
  localparam int ST_F1 = ST_Q2 + SQ2_STEPS;
  localparam int ST_G  = ST_F1 + 1;
  localparam int ST_H1 = ST_G + DIV_STEPS;
  localparam int ST_R1 = ST_H1 + 1;
  localparam int ST_R2 = ST_R1 + 1;
  localparam int ST_R3 = ST_R2 + 1;
  localparam int ST_R4 = ST_R3 + 1;
  localparam int ST_R5 = ST_R4 + 1;
  localparam int ST_R6 = ST_R5 + 1;
  localparam int ST_R7 = ST_R6 + 1;
  localparam int NST   = ST_R7;

  typedef struct packed {
    logic [2:0][31:0] hip;
    logic [2:0][31:0] tgt;
    logic [30:0] u;
    logic [30:0] l;
    logic side;
    logic [2:0] dneg;
    logic [2:0][29:0] a;
    logic [1:0] sh;
    logic [2:0][59:0] asq;
    logic [63:0] sq_v;
    logic [63:0] sq_r;
    logic [63:0] sq2_v;
    logic [63:0] sq2_r;
    logic signed [33:0] minr;
    logic signed [33:0] maxr;
    logic signed [34:0] cr;
    logic shortr;
    logic czero;
    logic crneg;
    logic cneg;
    logic cnumz;
    logic csat;
    logic axf;
    logic [29:0] us;
    logic [29:0] ls;
    logic [29:0] cs;
    logic [59:0] p_uu;
    logic [59:0] p_cc;
    logic [59:0] p_ll;
    logic [59:0] p_uc;
    logic [2:0][31:0] dv_r;
    logic [2:0][16:0] dv_q;
    logic [2:0] dv_lsb;
    logic [31:0] dv_d;
    logic [61:0] cd_r;
    logic [60:0] cd_d;
    logic [15:0] cd_q;
    logic [2:0][17:0] dir;
    logic [17:0] c;
    logic [16:0] s;
    logic [18:0] omc;
    logic [2:0][41:0] fm;
    logic [41:0] am;
    logic [33:0] sqd0;
    logic [33:0] sqd2;
    logic [32:0] csq;
    logic [2:0][31:0] foot;
    logic [31:0] ankle_y;
    logic [17:0] k0;
    logic [17:0] k2;
    logic [1:0] kneg;
    logic [5:0][21:0] pr;
    logic [21:0] kv;
    logic [2:0][21:0] x3;
    logic [21:0] kvo;
    logic [2:0][21:0] dc;
    logic [2:0][21:0] xs;
    logic [2:0][21:0] kk;
    logic [2:0][21:0] part;
    logic [2:0][21:0] kd;
    logic [2:0][41:0] km;
    logic [2:0][31:0] knee;
  } stg_t;

  typedef struct packed {
    logic [63:0] v;
    logic [63:0] r;
  } sq_t;

  typedef struct packed {
    logic [31:0] r;
    logic q;
  } dv_t;

  // One step of the digit-by-digit square root.
  function automatic sq_t sq_step(logic [63:0] v, logic [63:0] r, logic [63:0] b);
    sq_t o;
    logic [63:0] t;
    t = r + b;
    if (v >= t) begin
      o.v = v - t;
      o.r = (r >> 1) + b;
    end else begin
      o.v = v;
      o.r = r >> 1;
    end
    return o;
  endfunction

  // One step of restoring division: shift in one dividend bit.
  function automatic dv_t div_step(logic [31:0] r, logic bin, logic [31:0] d);
    dv_t o;
    logic [32:0] r2;
    r2 = {r, bin};
    o.q = 1'b0;
    if (r2 >= {1'b0, d}) begin
      r2 = r2 - {1'b0, d};
      o.q = 1'b1;
    end
    o.r = r2[31:0];
    return o;
  endfunction

  // Fixed-point product on magnitudes, rounded half away from zero.
  function automatic logic signed [41:0] mulq(logic signed [21:0] a, logic signed [35:0] b);
    logic [21:0] ua;
    logic [35:0] ub;
    logic [57:0] p;
    logic [41:0] r;
    ua = a[21] ? (~a + 22'd1) : a;
    ub = b[35] ? (~b + 36'd1) : b;
    p = 58'(ua) * 58'(ub) + (58'd1 << (FB - 1));
    r = p[FB+41:FB];
    return (a[21] ^ b[35]) ? $signed(~r + 42'd1) : $signed(r);
  endfunction

  // Saturate to the signed coordinate range.
  function automatic logic [31:0] sat(logic signed [43:0] x);
    logic signed [43:0] hi;
    logic signed [43:0] lo;
    hi = $signed({{(44 - CW + 1){1'b0}}, {(CW - 1){1'b1}}});
    lo = ~hi;
    if (x > hi) begin
      return hi[31:0];
    end else if (x < lo) begin
      return lo[31:0];
    end else begin
      return x[31:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/two_bone_leg_ik_solver_unit.sv =====
// Two-bone leg IK solver: fully pipelined Q16.16 solve, one item per cycle while busy is low.
// Depends on tbik_pkg (stage record, constants, step functions).
//
// Channel  | Ports                                           | Handshake
// request  | hip_*, target_*, upper_length, lower_length,    | start & !busy
//          | side_negative                                   |
// result   | knee_*, foot_*, ankle_*                         | done, one cycle
//
// An item is taken in every cycle that start is high and busy is low; busy
// is high only during reset. Each result is shown once its item has passed
// the stage chain: a 31-step reach square root, 17-step dividers for the
// direction with a 16-step cosine divider alongside, a 17-step square root
// for the axis and sine, a 17-step divider for the axis, and the rotation
// multipliers. Reset clears the valid bits of every stage. The receiver
// takes every result as shown.
`timescale 1ns / 1ps
`default_nettype none

module two_bone_leg_ik_solver_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output      logic               busy,
  input  wire logic signed [31:0] hip_x,
  input  wire logic signed [31:0] hip_y,
  input  wire logic signed [31:0] hip_z,
  input  wire logic signed [31:0] target_x,
  input  wire logic signed [31:0] target_y,
  input  wire logic signed [31:0] target_z,
  input  wire logic        [30:0] upper_length,
  input  wire logic        [30:0] lower_length,
  input  wire logic               side_negative,
  output      logic               done,
  output      logic signed [31:0] knee_x,
  output      logic signed [31:0] knee_y,
  output      logic signed [31:0] knee_z,
  output      logic signed [31:0] foot_x,
  output      logic signed [31:0] foot_y,
  output      logic signed [31:0] foot_z,
  output      logic signed [31:0] ankle_x,
  output      logic signed [31:0] ankle_y,
  output      logic signed [31:0] ankle_z
);

  tbik_pkg::stg_t pipe [0:tbik_pkg::NST];
  logic [tbik_pkg::NST:0] vld;
  tbik_pkg::stg_t n0;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[tbik_pkg::NST-1:0], start & ~busy};
    end
  end

  always_comb begin
    n0 = '0;
    n0.hip[0] = hip_x;
    n0.hip[1] = hip_y;
    n0.hip[2] = hip_z;
    n0.tgt[0] = target_x;
    n0.tgt[1] = target_y;
    n0.tgt[2] = target_z;
    n0.u = upper_length;
    n0.l = lower_length;
    n0.side = side_negative;
  end

  always_ff @(posedge clk) begin
    pipe[0] <= n0;
  end

  for (genvar g = 1; g <= tbik_pkg::NST; g++) begin : g_stage
    tbik_pkg::stg_t n;

    always_ff @(posedge clk) begin
      pipe[g] <= n;
    end

    if (g == tbik_pkg::ST_A1) begin : g_a1
      // Offsets, their magnitudes and the range shift for the reach.
      always_comb begin
        logic signed [32:0] dd;
        logic [2:0][32:0] md;
        logic [32:0] m;
        logic [30:0] ul;
        n = pipe[g-1];
        m = '0;
        for (int i = 0; i < 3; i++) begin
          dd = $signed({n.tgt[i][31], n.tgt[i]}) - $signed({n.hip[i][31], n.hip[i]});
          md[i] = dd[32] ? 33'(-dd) : 33'(dd);
          n.dneg[i] = dd[32];
          if (md[i] > m) begin
            m = md[i];
          end
        end
        priority if (m[32]) begin
          n.sh = 2'd3;
        end else if (m[31]) begin
          n.sh = 2'd2;
        end else if (m[30]) begin
          n.sh = 2'd1;
        end else begin
          n.sh = 2'd0;
        end
        for (int i = 0; i < 3; i++) begin
          n.a[i] = 30'(md[i] >> n.sh);
        end
        ul = (n.u > n.l) ? (n.u - n.l) : (n.l - n.u);
        n.minr = $signed(34'(ul) + 34'(tbik_pkg::K_CENT));
        n.maxr = $signed(34'(n.u) + 34'(n.l) - 34'(tbik_pkg::K_CENT));
      end
    end else if (g == tbik_pkg::ST_A2) begin : g_a2
      always_comb begin
        n = pipe[g-1];
        for (int i = 0; i < 3; i++) begin
          n.asq[i] = 60'(n.a[i]) * 60'(n.a[i]);
        end
      end
    end else if (g == tbik_pkg::ST_A3) begin : g_a3
      always_comb begin
        n = pipe[g-1];
        n.sq_v = 64'(n.asq[0]) + 64'(n.asq[1]) + 64'(n.asq[2]);
        n.sq_r = '0;
      end
    end else if (g >= tbik_pkg::ST_Q1 && g < tbik_pkg::ST_B1) begin : g_q1
      always_comb begin
        tbik_pkg::sq_t o;
        n = pipe[g-1];
        o = tbik_pkg::sq_step(n.sq_v, n.sq_r,
              64'd1 << (2 * (tbik_pkg::SQ1_STEPS - 1 - (g - tbik_pkg::ST_Q1))));
        n.sq_v = o.v;
        n.sq_r = o.r;
      end
    end else if (g == tbik_pkg::ST_B1) begin : g_b1
      // Reach, clamp and set-up of the three direction dividers.
      always_comb begin
        logic [33:0] reach;
        logic signed [35:0] rs;
        logic signed [35:0] mn;
        logic signed [35:0] mx;
        n = pipe[g-1];
        reach = 34'(n.sq_r[30:0]) << n.sh;
        rs = $signed({2'b00, reach});
        mn = 36'($signed(n.minr));
        mx = 36'($signed(n.maxr));
        priority if (rs < mn) begin
          n.cr = 35'(mn);
        end else if (rs > mx) begin
          n.cr = 35'(mx);
        end else begin
          n.cr = 35'(rs);
        end
        n.shortr = !((reach > 34'(tbik_pkg::K_MILLI)) && (n.sq_r[30:0] != '0));
        n.dv_d = {1'b0, n.sq_r[30:0]};
        for (int i = 0; i < 3; i++) begin
          n.dv_r[i] = 32'(n.a[i] >> 1);
          n.dv_lsb[i] = n.a[i][0];
          n.dv_q[i] = '0;
        end
      end
    end else if (g == tbik_pkg::ST_B2) begin : g_b2
      // Shift the lengths alike so that all of them fit below 2^30.
      always_comb begin
        logic signed [34:0] crv;
        logic [33:0] ucr;
        logic [33:0] mx;
        logic [2:0] t;
        n = pipe[g-1];
        crv = $signed(n.cr);
        ucr = crv[34] ? 34'(-crv) : 34'(crv);
        n.crneg = crv[34];
        n.czero = (n.u == '0) || (crv == '0);
        mx = 34'(n.u);
        if (34'(n.l) > mx) begin
          mx = 34'(n.l);
        end
        if (ucr > mx) begin
          mx = ucr;
        end
        priority if (mx[33]) begin
          t = 3'd4;
        end else if (mx[32]) begin
          t = 3'd3;
        end else if (mx[31]) begin
          t = 3'd2;
        end else if (mx[30]) begin
          t = 3'd1;
        end else begin
          t = 3'd0;
        end
        n.us = 30'(34'(n.u) >> t);
        n.ls = 30'(34'(n.l) >> t);
        n.cs = 30'(ucr >> t);
      end
    end else if (g == tbik_pkg::ST_B3) begin : g_b3
      always_comb begin
        n = pipe[g-1];
        n.p_uu = 60'(n.us) * 60'(n.us);
        n.p_cc = 60'(n.cs) * 60'(n.cs);
        n.p_ll = 60'(n.ls) * 60'(n.ls);
        n.p_uc = 60'(n.us) * 60'(n.cs);
      end
    end else if (g == tbik_pkg::ST_B4) begin : g_b4
      always_comb begin
        logic signed [62:0] num;
        logic [61:0] un;
        n = pipe[g-1];
        num = $signed(63'(n.p_uu) + 63'(n.p_cc) - 63'(n.p_ll));
        un = num[62] ? 62'(-num) : 62'(num);
        n.cd_d = {n.p_uc, 1'b0};
        n.cnumz = (num == '0);
        n.cneg = num[62] ^ n.crneg;
        n.csat = (un >= {1'b0, n.cd_d});
        n.cd_r = un;
        n.cd_q = '0;
      end
    end else if (g >= tbik_pkg::ST_D && g < tbik_pkg::ST_E1) begin : g_d
      // Direction quotients in three lanes; the cosine quotient alongside.
      always_comb begin
        tbik_pkg::dv_t o;
        logic [62:0] r2;
        n = pipe[g-1];
        for (int i = 0; i < 3; i++) begin
          o = tbik_pkg::div_step(n.dv_r[i], (g == tbik_pkg::ST_D) ? n.dv_lsb[i] : 1'b0,
                                 n.dv_d);
          n.dv_r[i] = o.r;
          n.dv_q[i] = {n.dv_q[i][15:0], o.q};
        end
        if (g - tbik_pkg::ST_D < tbik_pkg::CDIV_STEPS) begin
          r2 = {n.cd_r, 1'b0};
          if (r2 >= {2'b00, n.cd_d}) begin
            r2 = r2 - {2'b00, n.cd_d};
            n.cd_q = {n.cd_q[14:0], 1'b1};
          end else begin
            n.cd_q = {n.cd_q[14:0], 1'b0};
          end
          n.cd_r = r2[61:0];
        end
      end
    end else if (g == tbik_pkg::ST_E1) begin : g_e1
      always_comb begin
        logic [17:0] q;
        n = pipe[g-1];
        for (int i = 0; i < 3; i++) begin
          q = {1'b0, n.dv_q[i]};
          if (n.shortr) begin
            n.dir[i] = (i == 1) ? 18'(-tbik_pkg::ONE) : '0;
          end else begin
            n.dir[i] = n.dneg[i] ? (~q + 18'd1) : q;
          end
        end
        q = {2'b00, n.cd_q};
        priority if (n.czero || n.cnumz) begin
          n.c = '0;
        end else if (n.csat) begin
          n.c = n.cneg ? 18'(-tbik_pkg::ONE) : 18'(tbik_pkg::ONE);
        end else begin
          n.c = n.cneg ? (~q + 18'd1) : q;
        end
      end
    end else if (g == tbik_pkg::ST_E2) begin : g_e2
      always_comb begin
        logic signed [35:0] p0;
        logic signed [35:0] p2;
        logic signed [35:0] pc;
        n = pipe[g-1];
        p0 = $signed(n.dir[0]) * $signed(n.dir[0]);
        p2 = $signed(n.dir[2]) * $signed(n.dir[2]);
        pc = $signed(n.c) * $signed(n.c);
        n.sqd0 = p0[33:0];
        n.sqd2 = p2[33:0];
        n.csq = pc[32:0];
        for (int i = 0; i < 3; i++) begin
          n.fm[i] = tbik_pkg::mulq(22'($signed(n.dir[i])), 36'($signed(n.cr)));
        end
        n.am = tbik_pkg::mulq(22'(tbik_pkg::K_ANKLE), 36'(n.l));
      end
    end else if (g == tbik_pkg::ST_E3) begin : g_e3
      always_comb begin
        logic [34:0] lsq;
        logic signed [43:0] f;
        n = pipe[g-1];
        lsq = 35'(n.sqd0) + 35'(n.sqd2);
        n.axf = (64'(lsq) < 64'(tbik_pkg::K_AXIS_MIN));
        n.sq_v = 64'(lsq);
        n.sq_r = '0;
        n.sq2_v = (64'd1 << (2 * tbik_pkg::FB)) - 64'(n.csq);
        n.sq2_r = '0;
        n.omc = 19'(tbik_pkg::ONE) - 19'($signed(n.c));
        for (int i = 0; i < 3; i++) begin
          f = 44'($signed(n.hip[i])) + 44'($signed(n.fm[i]));
          n.foot[i] = tbik_pkg::sat(f);
          if (i == 1) begin
            n.ankle_y = tbik_pkg::sat(f + 44'($signed(n.am)));
          end
        end
      end
    end else if (g >= tbik_pkg::ST_Q2 && g < tbik_pkg::ST_F1) begin : g_q2
      // Axis length and sine roots run side by side.
      always_comb begin
        tbik_pkg::sq_t o;
        logic [63:0] b;
        n = pipe[g-1];
        b = 64'd1 << (2 * (tbik_pkg::SQ2_STEPS - 1 - (g - tbik_pkg::ST_Q2)));
        o = tbik_pkg::sq_step(n.sq_v, n.sq_r, b);
        n.sq_v = o.v;
        n.sq_r = o.r;
        o = tbik_pkg::sq_step(n.sq2_v, n.sq2_r, b);
        n.sq2_v = o.v;
        n.sq2_r = o.r;
      end
    end else if (g == tbik_pkg::ST_F1) begin : g_f1
      always_comb begin
        logic [17:0] nn;
        logic [16:0] m0;
        logic [16:0] m2;
        n = pipe[g-1];
        nn = (n.sq_r == '0) ? 18'd1 : n.sq_r[17:0];
        n.s = n.sq2_r[16:0];
        m2 = n.dir[2][17] ? 17'(-$signed(n.dir[2])) : n.dir[2][16:0];
        m0 = n.dir[0][17] ? 17'(-$signed(n.dir[0])) : n.dir[0][16:0];
        n.kneg[0] = ($signed(n.dir[2]) > 18'sd0);
        n.kneg[1] = n.dir[0][17];
        n.dv_d = 32'(nn);
        n.dv_r[0] = 32'(m2 >> 1);
        n.dv_lsb[0] = m2[0];
        n.dv_r[2] = 32'(m0 >> 1);
        n.dv_lsb[2] = m0[0];
        n.dv_r[1] = '0;
        n.dv_lsb[1] = 1'b0;
        for (int i = 0; i < 3; i++) begin
          n.dv_q[i] = '0;
        end
      end
    end else if (g >= tbik_pkg::ST_G && g < tbik_pkg::ST_H1) begin : g_g
      always_comb begin
        tbik_pkg::dv_t o;
        n = pipe[g-1];
        for (int i = 0; i < 3; i++) begin
          o = tbik_pkg::div_step(n.dv_r[i], (g == tbik_pkg::ST_G) ? n.dv_lsb[i] : 1'b0,
                                 n.dv_d);
          n.dv_r[i] = o.r;
          n.dv_q[i] = {n.dv_q[i][15:0], o.q};
        end
      end
    end else if (g == tbik_pkg::ST_H1) begin : g_h1
      // Bend axis: side axis when the horizontal part of the direction is tiny.
      always_comb begin
        logic [17:0] q0;
        logic [17:0] q2;
        n = pipe[g-1];
        q0 = {1'b0, n.dv_q[0]};
        q2 = {1'b0, n.dv_q[2]};
        if (n.axf) begin
          n.k0 = n.side ? 18'(-tbik_pkg::ONE) : 18'(tbik_pkg::ONE);
          n.k2 = '0;
        end else begin
          n.k0 = n.kneg[0] ? (~q0 + 18'd1) : q0;
          n.k2 = n.kneg[1] ? (~q2 + 18'd1) : q2;
        end
      end
    end else if (g == tbik_pkg::ST_R1) begin : g_r1
      always_comb begin
        logic signed [21:0] a0;
        logic signed [21:0] a2;
        n = pipe[g-1];
        a0 = 22'($signed(n.k0));
        a2 = 22'($signed(n.k2));
        n.pr[0] = 22'(tbik_pkg::mulq(a0, 36'($signed(n.dir[0]))));
        n.pr[1] = 22'(tbik_pkg::mulq(a2, 36'($signed(n.dir[2]))));
        n.pr[2] = 22'(tbik_pkg::mulq(a2, 36'($signed(n.dir[1]))));
        n.pr[3] = 22'(tbik_pkg::mulq(a2, 36'($signed(n.dir[0]))));
        n.pr[4] = 22'(tbik_pkg::mulq(a0, 36'($signed(n.dir[2]))));
        n.pr[5] = 22'(tbik_pkg::mulq(a0, 36'($signed(n.dir[1]))));
      end
    end else if (g == tbik_pkg::ST_R2) begin : g_r2
      always_comb begin
        n = pipe[g-1];
        n.kv = n.pr[0] + n.pr[1];
        n.x3[0] = ~n.pr[2] + 22'd1;
        n.x3[1] = n.pr[3] - n.pr[4];
        n.x3[2] = n.pr[5];
      end
    end else if (g == tbik_pkg::ST_R3) begin : g_r3
      always_comb begin
        n = pipe[g-1];
        n.kvo = 22'(tbik_pkg::mulq($signed(n.kv), 36'($signed(n.omc))));
        for (int i = 0; i < 3; i++) begin
          n.dc[i] = 22'(tbik_pkg::mulq(22'($signed(n.dir[i])), 36'($signed(n.c))));
          n.xs[i] = 22'(tbik_pkg::mulq($signed(n.x3[i]), 36'(n.s)));
        end
      end
    end else if (g == tbik_pkg::ST_R4) begin : g_r4
      always_comb begin
        n = pipe[g-1];
        n.kk[0] = 22'(tbik_pkg::mulq(22'($signed(n.k0)), 36'($signed(n.kvo))));
        n.kk[1] = '0;
        n.kk[2] = 22'(tbik_pkg::mulq(22'($signed(n.k2)), 36'($signed(n.kvo))));
        for (int i = 0; i < 3; i++) begin
          n.part[i] = n.dc[i] + n.xs[i];
        end
      end
    end else if (g == tbik_pkg::ST_R5) begin : g_r5
      always_comb begin
        n = pipe[g-1];
        for (int i = 0; i < 3; i++) begin
          n.kd[i] = n.part[i] + n.kk[i];
        end
      end
    end else if (g == tbik_pkg::ST_R6) begin : g_r6
      always_comb begin
        n = pipe[g-1];
        for (int i = 0; i < 3; i++) begin
          n.km[i] = tbik_pkg::mulq($signed(n.kd[i]), 36'(n.u));
        end
      end
    end else begin : g_r7
      always_comb begin
        n = pipe[g-1];
        for (int i = 0; i < 3; i++) begin
          n.knee[i] = tbik_pkg::sat(44'($signed(n.hip[i])) + 44'($signed(n.km[i])));
        end
      end
    end
  end

  assign done    = vld[tbik_pkg::NST];
  assign knee_x  = pipe[tbik_pkg::NST].knee[0];
  assign knee_y  = pipe[tbik_pkg::NST].knee[1];
  assign knee_z  = pipe[tbik_pkg::NST].knee[2];
  assign foot_x  = pipe[tbik_pkg::NST].foot[0];
  assign foot_y  = pipe[tbik_pkg::NST].foot[1];
  assign foot_z  = pipe[tbik_pkg::NST].foot[2];
  assign ankle_x = pipe[tbik_pkg::NST].foot[0];
  assign ankle_y = pipe[tbik_pkg::NST].ankle_y;
  assign ankle_z = pipe[tbik_pkg::NST].foot[2];

endmodule

`default_nettype wire
